### design/vgec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector glyph endpoint clamp: shared package
// Field widths, register indexes, reset values and the types that travel
// between the pipeline sections.
// ----------------------------------------------------------------------------
package vgec_pkg;

  // Field widths of the item and result ports.
  localparam int COL_W   = 11;
  localparam int ROW_W   = 11;
  localparam int VEL_W   = 16;
  localparam int START_W = 15;
  localparam int END_W   = 16;

  // Configuration register widths.
  localparam int CW_W = 15;
  localparam int CH_W = 14;
  localparam int AS_W = 10;
  localparam int ML_W = 12;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARROW_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd3;

  localparam logic [CW_W-1:0] RST_CELL_WIDTH  = 15'd300;
  localparam logic [CH_W-1:0] RST_CELL_HEIGHT = 14'd200;
  localparam logic [AS_W-1:0] RST_ARROW_SCALE = 10'd100;
  localparam logic [ML_W-1:0] RST_MAX_LENGTH  = 12'd160;

  // Internal datapath widths.
  localparam int PROD_W     = VEL_W + AS_W + 1; // signed velocity times gain
  localparam int MAG_W      = 25;               // magnitude of that product
  localparam int SQ_W       = 51;               // sum of squares
  localparam int ROOT_W     = 53;               // square root working width
  localparam int LEN_W      = 26;               // integer vector length
  localparam int NUM_W      = MAG_W + ML_W;     // magnitude times max length
  localparam int UNC_W      = 17;               // unclamped rounded magnitude
  localparam int REM_W      = 40;               // divider remainder
  localparam int Q_W        = ML_W;             // clamped quotient
  localparam int SQRT_STEPS = 26;               // one root bit per stage

  typedef logic [ROOT_W-1:0] vgec_root_t;
  typedef logic [REM_W-1:0]  vgec_rem_t;

  typedef struct packed {
    logic [CW_W-1:0] cell_width;
    logic [CH_W-1:0] cell_height;
    logic [AS_W-1:0] arrow_scale;
    logic [ML_W-1:0] max_length;
  } vgec_cfg_t;

  // Per-item data that rides along beside the root and divide work.
  typedef struct packed {
    logic [START_W-1:0] sx;
    logic [START_W-1:0] sy;
    logic               neg_x;
    logic               neg_y;
    logic [UNC_W-1:0]   unc_x;
    logic [UNC_W-1:0]   unc_y;
    logic               clamp;
  } vgec_tail_t;

endpackage

### design/vector_glyph_endpoint_clamp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector glyph endpoint clamp: top level
// Start and end points of a velocity glyph for one grid cell, with the
// vector length clamped to a programmable maximum.
// ----------------------------------------------------------------------------
// Throughput: one item per clock while the skid stage is empty; the 26-stage
// square root and the 12-stage divider each resolve one bit per stage, so every
// stage takes a new item. A stalled output holds one result in the output
// register and one more in a skid stage before the input stops taking items.
// Reset empties the pipeline and loads the register defaults 300, 200, 100
// and 160 into cell width, cell height, arrow scale and maximum length.
module vector_glyph_endpoint_clamp_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [vgec_pkg::COL_W-1:0]            column_i,
  input  logic [vgec_pkg::ROW_W-1:0]            row_i,
  input  logic signed [vgec_pkg::VEL_W-1:0]     vel_x_i,
  input  logic signed [vgec_pkg::VEL_W-1:0]     vel_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [vgec_pkg::START_W-1:0]          start_x_o,
  output logic [vgec_pkg::START_W-1:0]          start_y_o,
  output logic signed [vgec_pkg::END_W-1:0]     end_x_o,
  output logic signed [vgec_pkg::END_W-1:0]     end_y_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [vgec_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [vgec_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // Configuration registers.
  vgec_pkg::vgec_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_width  <= vgec_pkg::RST_CELL_WIDTH;
      cfg_q.cell_height <= vgec_pkg::RST_CELL_HEIGHT;
      cfg_q.arrow_scale <= vgec_pkg::RST_ARROW_SCALE;
      cfg_q.max_length  <= vgec_pkg::RST_MAX_LENGTH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vgec_pkg::CFG_CELL_WIDTH: begin
          cfg_q.cell_width <= cfg_data_i[vgec_pkg::CW_W-1:0];
        end
        vgec_pkg::CFG_CELL_HEIGHT: begin
          cfg_q.cell_height <= cfg_data_i[vgec_pkg::CH_W-1:0];
        end
        vgec_pkg::CFG_ARROW_SCALE: begin
          cfg_q.arrow_scale <= cfg_data_i[vgec_pkg::AS_W-1:0];
        end
        vgec_pkg::CFG_MAX_LENGTH: begin
          cfg_q.max_length <= cfg_data_i[vgec_pkg::ML_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Whole pipeline advances together while the output skid stage is empty.
  logic pipe_en;

  assign in_ready_o = pipe_en;

  logic                       fr_valid;
  vgec_pkg::vgec_tail_t       fr_tail;
  logic [vgec_pkg::NUM_W-1:0] fr_num_x, fr_num_y;
  logic [vgec_pkg::SQ_W-1:0]  fr_l2;

  vgec_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (in_valid_i),
    .column_i (column_i),
    .row_i    (row_i),
    .vel_x_i  (vel_x_i),
    .vel_y_i  (vel_y_i),
    .cfg_i    (cfg_q),
    .valid_o  (fr_valid),
    .tail_o   (fr_tail),
    .num_x_o  (fr_num_x),
    .num_y_o  (fr_num_y),
    .l2_o     (fr_l2)
  );

  logic                       sq_valid;
  vgec_pkg::vgec_tail_t       sq_tail;
  logic [vgec_pkg::NUM_W-1:0] sq_num_x, sq_num_y;
  logic [vgec_pkg::LEN_W-1:0] sq_len;

  vgec_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (fr_valid),
    .tail_i  (fr_tail),
    .num_x_i (fr_num_x),
    .num_y_i (fr_num_y),
    .l2_i    (fr_l2),
    .valid_o (sq_valid),
    .tail_o  (sq_tail),
    .num_x_o (sq_num_x),
    .num_y_o (sq_num_y),
    .len_o   (sq_len)
  );

  logic                     dv_valid;
  vgec_pkg::vgec_tail_t     dv_tail;
  logic [vgec_pkg::Q_W-1:0] dv_q_x, dv_q_y;

  vgec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (sq_valid),
    .tail_i  (sq_tail),
    .num_x_i (sq_num_x),
    .num_y_i (sq_num_y),
    .len_i   (sq_len),
    .valid_o (dv_valid),
    .tail_o  (dv_tail),
    .q_x_o   (dv_q_x),
    .q_y_o   (dv_q_y)
  );

  vgec_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dv_valid),
    .tail_i      (dv_tail),
    .q_x_i       (dv_q_x),
    .q_y_i       (dv_q_y),
    .ready_o     (pipe_en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .start_x_o   (start_x_o),
    .start_y_o   (start_y_o),
    .end_x_o     (end_x_o),
    .end_y_o     (end_y_o)
  );

endmodule

### design/vgec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector glyph endpoint clamp: front section
// Four stages: gain and pitch products, magnitudes and start saturation,
// squares and numerators, then the squared length and the clamp decision.
// ----------------------------------------------------------------------------
module vgec_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [vgec_pkg::COL_W-1:0]      column_i,
  input  logic [vgec_pkg::ROW_W-1:0]      row_i,
  input  logic signed [vgec_pkg::VEL_W-1:0] vel_x_i,
  input  logic signed [vgec_pkg::VEL_W-1:0] vel_y_i,
  input  vgec_pkg::vgec_cfg_t             cfg_i,
  output logic                            valid_o,
  output vgec_pkg::vgec_tail_t            tail_o,
  output logic [vgec_pkg::NUM_W-1:0]      num_x_o,
  output logic [vgec_pkg::NUM_W-1:0]      num_y_o,
  output logic [vgec_pkg::SQ_W-1:0]       l2_o
);

  localparam int SXR_W = vgec_pkg::COL_W + vgec_pkg::CW_W;
  localparam int SYR_W = vgec_pkg::ROW_W + vgec_pkg::CH_W;
  localparam int PW    = vgec_pkg::PROD_W;
  localparam int MW    = vgec_pkg::MAG_W;
  localparam int SW    = vgec_pkg::START_W;

  logic [3:0] v_q;

  // Stage 1: velocity times gain, cell index times pitch.
  logic signed [PW-1:0] s1_px_q, s1_py_q, s1_px_d, s1_py_d;
  logic [SXR_W-1:0]     s1_sxr_q, s1_sxr_d;
  logic [SYR_W-1:0]     s1_syr_q, s1_syr_d;

  always_comb begin
    s1_px_d  = vel_x_i * $signed({1'b0, cfg_i.arrow_scale});
    s1_py_d  = vel_y_i * $signed({1'b0, cfg_i.arrow_scale});
    s1_sxr_d = column_i * cfg_i.cell_width;
    s1_syr_d = row_i * cfg_i.cell_height;
  end

  // Stage 2: magnitudes, signs and saturated start point.
  logic [PW-1:0] abs_x, abs_y;
  logic [MW-1:0] s2_ax_q, s2_ay_q;
  logic          s2_negx_q, s2_negy_q;
  logic [SW-1:0] s2_sx_q, s2_sy_q, s2_sx_d, s2_sy_d;

  always_comb begin
    abs_x   = s1_px_q[PW-1] ? -s1_px_q : s1_px_q;
    abs_y   = s1_py_q[PW-1] ? -s1_py_q : s1_py_q;
    s2_sx_d = (|s1_sxr_q[SXR_W-1:SW]) ? {SW{1'b1}} : s1_sxr_q[SW-1:0];
    s2_sy_d = (|s1_syr_q[SYR_W-1:SW]) ? {SW{1'b1}} : s1_syr_q[SW-1:0];
  end

  // Stage 3: squares, clamp numerators, limit square and unclamped rounding.
  logic [2*MW-1:0]                  s3_ax2_q, s3_ay2_q;
  logic [vgec_pkg::NUM_W-1:0]       s3_numx_q, s3_numy_q;
  logic [2*vgec_pkg::ML_W-1:0]      s3_limsq_q;
  vgec_pkg::vgec_tail_t             s3_tail_q, s3_tail_d;
  logic [MW-1:0]                    rnd_x, rnd_y;

  always_comb begin
    rnd_x           = s2_ax_q + MW'(128);
    rnd_y           = s2_ay_q + MW'(128);
    s3_tail_d.sx    = s2_sx_q;
    s3_tail_d.sy    = s2_sy_q;
    s3_tail_d.neg_x = s2_negx_q;
    s3_tail_d.neg_y = s2_negy_q;
    s3_tail_d.unc_x = rnd_x[MW-1:8];
    s3_tail_d.unc_y = rnd_y[MW-1:8];
    s3_tail_d.clamp = 1'b0;
  end

  // Stage 4: squared length and comparison with the squared limit.
  logic [vgec_pkg::SQ_W-1:0] l2_d, lim2;
  vgec_pkg::vgec_tail_t      s4_tail_q, s4_tail_d;

  always_comb begin
    l2_d            = vgec_pkg::SQ_W'(s3_ax2_q) + vgec_pkg::SQ_W'(s3_ay2_q);
    lim2            = vgec_pkg::SQ_W'({s3_limsq_q, 16'h0000});
    s4_tail_d       = s3_tail_q;
    s4_tail_d.clamp = l2_d > lim2;
  end

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_px_q    <= s1_px_d;
      s1_py_q    <= s1_py_d;
      s1_sxr_q   <= s1_sxr_d;
      s1_syr_q   <= s1_syr_d;
      s2_ax_q    <= abs_x[MW-1:0];
      s2_ay_q    <= abs_y[MW-1:0];
      s2_negx_q  <= s1_px_q[PW-1];
      s2_negy_q  <= s1_py_q[PW-1];
      s2_sx_q    <= s2_sx_d;
      s2_sy_q    <= s2_sy_d;
      s3_ax2_q   <= s2_ax_q * s2_ax_q;
      s3_ay2_q   <= s2_ay_q * s2_ay_q;
      s3_numx_q  <= s2_ax_q * cfg_i.max_length;
      s3_numy_q  <= s2_ay_q * cfg_i.max_length;
      s3_limsq_q <= cfg_i.max_length * cfg_i.max_length;
      s3_tail_q  <= s3_tail_d;
      s4_tail_q  <= s4_tail_d;
      l2_o       <= l2_d;
      num_x_o    <= s3_numx_q;
      num_y_o    <= s3_numy_q;
    end
  end

  assign valid_o = v_q[3];
  assign tail_o  = s4_tail_q;

endmodule

### design/vgec_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector glyph endpoint clamp: square root pipeline
// Integer square root of the squared length, one result bit per stage,
// with the remaining per-item data carried alongside.
// ----------------------------------------------------------------------------
module vgec_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  vgec_pkg::vgec_tail_t       tail_i,
  input  logic [vgec_pkg::NUM_W-1:0] num_x_i,
  input  logic [vgec_pkg::NUM_W-1:0] num_y_i,
  input  logic [vgec_pkg::SQ_W-1:0]  l2_i,
  output logic                       valid_o,
  output vgec_pkg::vgec_tail_t       tail_o,
  output logic [vgec_pkg::NUM_W-1:0] num_x_o,
  output logic [vgec_pkg::NUM_W-1:0] num_y_o,
  output logic [vgec_pkg::LEN_W-1:0] len_o
);

  localparam int STEPS = vgec_pkg::SQRT_STEPS;

  logic [STEPS-1:0]           v_q;
  vgec_pkg::vgec_root_t       rem_q [STEPS];
  vgec_pkg::vgec_root_t       res_q [STEPS];
  vgec_pkg::vgec_tail_t       tail_q [STEPS];
  logic [vgec_pkg::NUM_W-1:0] numx_q [STEPS];
  logic [vgec_pkg::NUM_W-1:0] numy_q [STEPS];

  genvar i;
  for (i = 0; i < STEPS; i++) begin : g_step
    localparam vgec_pkg::vgec_root_t BIT = vgec_pkg::vgec_root_t'(1) << (2 * (STEPS - 1 - i));

    logic                       in_v;
    vgec_pkg::vgec_root_t       in_rem, in_res, trial, rem_d, res_d;
    vgec_pkg::vgec_tail_t       in_tail;
    logic [vgec_pkg::NUM_W-1:0] in_numx, in_numy;
    logic                       take;

    if (i == 0) begin : g_first
      assign in_v    = valid_i;
      assign in_rem  = vgec_pkg::vgec_root_t'(l2_i);
      assign in_res  = '0;
      assign in_tail = tail_i;
      assign in_numx = num_x_i;
      assign in_numy = num_y_i;
    end else begin : g_next
      assign in_v    = v_q[i-1];
      assign in_rem  = rem_q[i-1];
      assign in_res  = res_q[i-1];
      assign in_tail = tail_q[i-1];
      assign in_numx = numx_q[i-1];
      assign in_numy = numy_q[i-1];
    end

    // Try the current bit: subtract when the remainder allows it.
    always_comb begin
      trial = in_res + BIT;
      take  = in_rem >= trial;
      rem_d = take ? in_rem - trial : in_rem;
      res_d = take ? (in_res >> 1) + BIT : in_res >> 1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        res_q[i]  <= res_d;
        tail_q[i] <= in_tail;
        numx_q[i] <= in_numx;
        numy_q[i] <= in_numy;
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign tail_o  = tail_q[STEPS-1];
  assign num_x_o = numx_q[STEPS-1];
  assign num_y_o = numy_q[STEPS-1];
  assign len_o   = res_q[STEPS-1][vgec_pkg::LEN_W-1:0];

endmodule

### design/vgec_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector glyph endpoint clamp: rounding divider pipeline
// Computes (2*num + len) / (2*len) for both components in parallel lanes,
// one quotient bit per stage, after a stage that forms the dividends.
// ----------------------------------------------------------------------------
module vgec_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  vgec_pkg::vgec_tail_t       tail_i,
  input  logic [vgec_pkg::NUM_W-1:0] num_x_i,
  input  logic [vgec_pkg::NUM_W-1:0] num_y_i,
  input  logic [vgec_pkg::LEN_W-1:0] len_i,
  output logic                       valid_o,
  output vgec_pkg::vgec_tail_t       tail_o,
  output logic [vgec_pkg::Q_W-1:0]   q_x_o,
  output logic [vgec_pkg::Q_W-1:0]   q_y_o
);

  localparam int QW = vgec_pkg::Q_W;

  // Dividend stage: numerator doubled plus length for round to nearest.
  logic                       init_v_q;
  vgec_pkg::vgec_rem_t        init_rx_q, init_ry_q;
  logic [vgec_pkg::LEN_W-1:0] init_len_q;
  vgec_pkg::vgec_tail_t       init_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_v_q <= 1'b0;
    end else if (en_i) begin
      init_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      init_rx_q   <= vgec_pkg::vgec_rem_t'({num_x_i, 1'b0}) + vgec_pkg::vgec_rem_t'(len_i);
      init_ry_q   <= vgec_pkg::vgec_rem_t'({num_y_i, 1'b0}) + vgec_pkg::vgec_rem_t'(len_i);
      init_len_q  <= len_i;
      init_tail_q <= tail_i;
    end
  end

  // Restoring division stages.
  logic [QW-1:0]              v_q;
  vgec_pkg::vgec_rem_t        rx_q [QW];
  vgec_pkg::vgec_rem_t        ry_q [QW];
  logic [QW-1:0]              qx_q [QW];
  logic [QW-1:0]              qy_q [QW];
  logic [vgec_pkg::LEN_W-1:0] len_q [QW];
  vgec_pkg::vgec_tail_t       tail_q [QW];

  genvar i;
  for (i = 0; i < QW; i++) begin : g_step
    logic                       in_v;
    vgec_pkg::vgec_rem_t        in_rx, in_ry, sub, rx_d, ry_d;
    logic [QW-1:0]              in_qx, in_qy;
    logic [vgec_pkg::LEN_W-1:0] in_len;
    vgec_pkg::vgec_tail_t       in_tail;
    logic                       take_x, take_y;

    if (i == 0) begin : g_first
      assign in_v    = init_v_q;
      assign in_rx   = init_rx_q;
      assign in_ry   = init_ry_q;
      assign in_qx   = '0;
      assign in_qy   = '0;
      assign in_len  = init_len_q;
      assign in_tail = init_tail_q;
    end else begin : g_next
      assign in_v    = v_q[i-1];
      assign in_rx   = rx_q[i-1];
      assign in_ry   = ry_q[i-1];
      assign in_qx   = qx_q[i-1];
      assign in_qy   = qy_q[i-1];
      assign in_len  = len_q[i-1];
      assign in_tail = tail_q[i-1];
    end

    // Divisor is twice the length, aligned to this quotient bit.
    always_comb begin
      sub    = vgec_pkg::vgec_rem_t'({in_len, 1'b0}) << (QW - 1 - i);
      take_x = in_rx >= sub;
      take_y = in_ry >= sub;
      rx_d   = take_x ? in_rx - sub : in_rx;
      ry_d   = take_y ? in_ry - sub : in_ry;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[i]   <= rx_d;
        ry_q[i]   <= ry_d;
        qx_q[i]   <= {in_qx[QW-2:0], take_x};
        qy_q[i]   <= {in_qy[QW-2:0], take_y};
        len_q[i]  <= in_len;
        tail_q[i] <= in_tail;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign tail_o  = tail_q[QW-1];
  assign q_x_o   = qx_q[QW-1];
  assign q_y_o   = qy_q[QW-1];

  // A clamped item has a nonzero length and a quotient that fits its bits.
  a_clamp_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (init_v_q && init_tail_q.clamp) |-> (init_len_q != '0))
    else $error("clamped item reached the divider with zero length");

  a_clamp_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (init_v_q && init_tail_q.clamp) |->
      (init_rx_q < (vgec_pkg::vgec_rem_t'({init_len_q, 1'b0}) << QW)) &&
      (init_ry_q < (vgec_pkg::vgec_rem_t'({init_len_q, 1'b0}) << QW)))
    else $error("clamped quotient would overflow the divider");

endmodule

### design/vgec_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector glyph endpoint clamp: output section
// Signs and saturates the displacement, adds it to the start point, and
// hands results out through an output register with a skid stage.
// ----------------------------------------------------------------------------
module vgec_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  vgec_pkg::vgec_tail_t                tail_i,
  input  logic [vgec_pkg::Q_W-1:0]            q_x_i,
  input  logic [vgec_pkg::Q_W-1:0]            q_y_i,
  output logic                                ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [vgec_pkg::START_W-1:0]        start_x_o,
  output logic [vgec_pkg::START_W-1:0]        start_y_o,
  output logic signed [vgec_pkg::END_W-1:0]   end_x_o,
  output logic signed [vgec_pkg::END_W-1:0]   end_y_o
);

  localparam int UW = vgec_pkg::UNC_W;
  localparam int EW = vgec_pkg::END_W;
  localparam int SW = vgec_pkg::START_W;

  typedef struct packed {
    logic [SW-1:0] sx;
    logic [SW-1:0] sy;
    logic [EW-1:0] ex;
    logic [EW-1:0] ey;
  } vgec_res_t;

  // Saturate an 18-bit two's complement value to 16 bits.
  function automatic logic [EW-1:0] sat_end(input logic [UW:0] v);
    logic [EW-1:0] r;
    if ((v[UW:EW-1] == '0) || (v[UW:EW-1] == '1)) begin
      r = v[EW-1:0];
    end else begin
      r = v[UW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    end
    return r;
  endfunction

  logic en;
  logic f1_v_q, f2_v_q;

  // Stage F1: choose clamped or plain magnitude, apply sign, saturate.
  logic [UW-1:0] mag_x, mag_y;
  logic [UW:0]   sig_x, sig_y;
  logic [EW-1:0] f1_dx_q, f1_dy_q;
  logic [SW-1:0] f1_sx_q, f1_sy_q;

  always_comb begin
    mag_x = tail_i.clamp ? UW'(q_x_i) : tail_i.unc_x;
    mag_y = tail_i.clamp ? UW'(q_y_i) : tail_i.unc_y;
    sig_x = tail_i.neg_x ? -{1'b0, mag_x} : {1'b0, mag_x};
    sig_y = tail_i.neg_y ? -{1'b0, mag_y} : {1'b0, mag_y};
  end

  // Stage F2: end point is start plus displacement, saturated.
  logic [UW:0] sum_x, sum_y;
  vgec_res_t   f2_res_q;

  always_comb begin
    sum_x = {3'b000, f1_sx_q} + {{(UW+1-EW){f1_dx_q[EW-1]}}, f1_dx_q};
    sum_y = {3'b000, f1_sy_q} + {{(UW+1-EW){f1_dy_q[EW-1]}}, f1_dy_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= valid_i;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_dx_q     <= sat_end(sig_x);
      f1_dy_q     <= sat_end(sig_y);
      f1_sx_q     <= tail_i.sx;
      f1_sy_q     <= tail_i.sy;
      f2_res_q.sx <= f1_sx_q;
      f2_res_q.sy <= f1_sy_q;
      f2_res_q.ex <= sat_end(sum_x);
      f2_res_q.ey <= sat_end(sum_y);
    end
  end

  // Output register and skid stage. The pipeline advances while the skid
  // stage is empty, so one more item is taken while a result waits.
  logic      out_valid_q, skid_valid_q;
  vgec_res_t out_q, skid_q;
  logic      push;

  assign en   = !skid_valid_q;
  assign push = f2_v_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!skid_valid_q) begin
      if (push) begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end else if (out_ready_i) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      if (push) begin
        if (!out_valid_q || out_ready_i) begin
          out_q <= f2_res_q;
        end else begin
          skid_q <= f2_res_q;
        end
      end
    end else if (out_ready_i) begin
      out_q <= skid_q;
    end
  end

  assign ready_o     = en;
  assign out_valid_o = out_valid_q;
  assign start_x_o   = out_q.sx;
  assign start_y_o   = out_q.sy;
  assign end_x_o     = out_q.ex;
  assign end_y_o     = out_q.ey;

  // The skid stage only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while the output register is empty");

  a_skid_catches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f2_v_q && !skid_valid_q && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("item pushed into a stalled output was not caught");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_valid_q) |-> out_valid_q)
    else $error("skid stage drained without refilling the output register");

endmodule
